[hdl/rlm_pkg.sv]
package rlm_pkg;

  localparam int SUM_W       = 40;
  localparam int CNT_W       = 13;
  localparam int TERM_W      = 29;
  localparam int DIV_W       = 16;
  localparam int DIV_STEP_W  = $clog2(SUM_W + 1);
  localparam int ROOT_W      = SUM_W / 2;
  localparam int ROOT_STEP_W = $clog2(ROOT_W + 1);
  localparam int ROOT_REM_W  = ROOT_W + 2;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  localparam logic       REG_DECAY        = 1'b0;
  localparam logic       REG_FULL_SCALE   = 1'b1;
  localparam logic [15:0] DECAY_RESET      = 16'd60948;
  localparam logic [14:0] FULL_SCALE_RESET = 15'd5571;
  localparam logic [15:0] ONE_Q15          = 16'd32768;
  localparam logic [14:0] LEVEL_MAX        = 15'd32767;

  typedef struct packed {
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_frame;
  } frame_t;

  typedef struct packed {
    logic [14:0] smoothed_level;
    logic [15:0] scaled_level;
    logic [14:0] block_rms;
  } level_t;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] count;
  } block_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

[hdl/rms_level_meter_smoothed.sv]
// Frames are taken one per cycle unless stalled; a frame that does not end a block
// gives no result. A block-end request passes the front stages, a 40-step shared
// divider for the mean, 20 root steps, the multiply and sum smoothing states and,
// unless full scale is 0, a second 40-step divide for scaling. The back end takes one
// block end at a time; a 4-entry queue holds pending block ends, then input stalls.
// Synchronous reset clears sum, count and smoothed level and loads default config.
module rms_level_meter_smoothed #(
  parameter int MAX_FRAMES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  rlm_pkg::frame_t frame,
  input  logic            frame_valid,
  output logic            frame_stall,
  output rlm_pkg::level_t level,
  output logic            level_valid,
  input  logic            level_stall,
  input  logic            write_enable,
  input  logic            reg_index,
  input  logic [15:0]     write_data
);
  import rlm_pkg::*;

  logic [15:0]        decay_coeff;
  logic [14:0]        full_scale_level;
  logic               push;
  block_t             push_data;
  logic               pop;
  block_t             head;
  logic               empty;
  logic [FIFO_AW:0]   fifo_level;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_coeff      <= DECAY_RESET;
      full_scale_level <= FULL_SCALE_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        REG_DECAY:      decay_coeff      <= write_data;
        REG_FULL_SCALE: full_scale_level <= write_data[14:0];
        default: ;
      endcase
    end
  end

  rlm_front #(
    .MAX_FRAMES(MAX_FRAMES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .level       (fifo_level),
    .push        (push),
    .push_data   (push_data)
  );

  rlm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .level     (fifo_level)
  );

  rlm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rlm_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .decay_coeff      (decay_coeff),
    .full_scale_level (full_scale_level),
    .div_req          (div_req),
    .div_rsp          (div_rsp),
    .level_valid      (level_valid),
    .level_stall      (level_stall),
    .level            (level)
  );

endmodule

[hdl/rlm_div.sv]
module rlm_div (
  input  logic              clk,
  input  logic              rst,
  input  rlm_pkg::div_req_t req,
  output rlm_pkg::div_rsp_t rsp
);
  import rlm_pkg::*;

  logic [SUM_W-1:0]      dq;
  logic [DIV_W-1:0]      rem;
  logic [DIV_W-1:0]      dsr;
  logic [DIV_STEP_W-1:0] steps;
  logic                  busy;
  logic                  done;
  logic [DIV_W:0]        rem_sh;
  logic                  qbit;
  logic [DIV_W:0]        rem_sub;

  always_comb begin
    rem_sh  = {rem, dq[SUM_W-1]};
    qbit    = rem_sh >= {1'b0, dsr};
    rem_sub = rem_sh - {1'b0, dsr};
    rsp     = '{done: done, quotient: dq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        dq    <= req.dividend;
        dsr   <= req.divisor;
        rem   <= '0;
        steps <= DIV_STEP_W'(SUM_W);
        busy  <= 1'b1;
      end else if (busy) begin
        dq    <= {dq[SUM_W-2:0], qbit};
        rem   <= qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
        steps <= steps - 1'b1;
        if (steps == DIV_STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hdl/rlm_fifo.sv]
module rlm_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rlm_pkg::block_t         push_data,
  input  logic                    pop,
  output rlm_pkg::block_t         head,
  output logic                    empty,
  output logic [rlm_pkg::FIFO_AW:0] level
);
  import rlm_pkg::*;

  block_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;

  always_comb begin
    head  = mem[rd_ptr];
    empty = level == '0;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

[hdl/rlm_front.sv]
module rlm_front #(
  parameter int MAX_FRAMES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rlm_pkg::frame_t           frame,
  input  logic                      frame_valid,
  output logic                      frame_stall,
  input  logic [rlm_pkg::FIFO_AW:0] level,
  output logic                      push,
  output rlm_pkg::block_t           push_data
);
  import rlm_pkg::*;

  logic               accept;
  logic               s1_valid;
  logic signed [15:0] s1_sample;
  logic               s1_last;
  logic signed [31:0] sq;
  logic               s2_valid;
  logic [TERM_W-1:0]  s2_term;
  logic               s2_last;
  logic [SUM_W-1:0]   sum;
  logic [CNT_W-1:0]   count;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic [CNT_W-1:0]   count_next;
  logic               block_end;

  // keep room in the queue for every frame still in flight
  always_comb begin
    frame_stall = (level + (FIFO_AW+1)'(s1_valid) + (FIFO_AW+1)'(s2_valid))
                  >= (FIFO_AW+1)'(FIFO_DEPTH);
    accept      = frame_valid && !frame_stall;
    sq          = s1_sample * s1_sample;
    sum_add     = {1'b0, sum} + (SUM_W+1)'(s2_term);
    sum_sat     = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
    count_next  = count + 1'b1;
    block_end   = s2_last || (count_next >= CNT_W'(MAX_FRAMES));
    push        = s2_valid && block_end;
    push_data   = '{sum: sum_sat, count: count_next};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_sample <= frame.left_sample;
      s1_last   <= frame.last_frame;
    end
    if (s1_valid) begin
      s2_term <= sq[TERM_W+1:2];
      s2_last <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      sum      <= '0;
      count    <= '0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      if (s2_valid) begin
        if (block_end) begin
          sum   <= '0;
          count <= '0;
        end else begin
          sum   <= sum_sat;
          count <= count_next;
        end
      end
    end
  end

endmodule

[hdl/rlm_back.sv]
module rlm_back (
  input  logic              clk,
  input  logic              rst,
  input  rlm_pkg::block_t   head,
  input  logic              empty,
  output logic              pop,
  input  logic [15:0]       decay_coeff,
  input  logic [14:0]       full_scale_level,
  output rlm_pkg::div_req_t div_req,
  input  rlm_pkg::div_rsp_t div_rsp,
  output logic              level_valid,
  input  logic              level_stall,
  output rlm_pkg::level_t   level
);
  import rlm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_ROOT,
    ST_MUL,
    ST_SUM,
    ST_SCALE,
    ST_OUT
  } state_t;

  state_t                 state;
  logic [SUM_W-1:0]       sq_val;
  logic [ROOT_W-1:0]      root;
  logic [ROOT_REM_W-1:0]  srem;
  logic [ROOT_STEP_W-1:0] steps;
  logic [14:0]            rms;
  logic [30:0]            p_old;
  logic [31:0]            p_new;
  logic [14:0]            smoothed_store;
  logic [14:0]            sm;
  logic [15:0]            scaled;

  logic [ROOT_REM_W+1:0]  sq_sh;
  logic [ROOT_REM_W+1:0]  sq_trial;
  logic                   sq_fit;
  logic [14:0]            rms_c;
  logic [16:0]            weight;
  logic [33:0]            total;
  logic [14:0]            sm_c;

  always_comb begin
    pop      = (state == ST_IDLE) && !empty;
    sq_sh    = {srem, sq_val[SUM_W-1:SUM_W-2]};
    sq_trial = {2'b00, root, 2'b01};
    sq_fit   = sq_sh >= sq_trial;
    rms_c    = (root > ROOT_W'(LEVEL_MAX)) ? LEVEL_MAX : root[14:0];
    weight   = 17'h10000 - {1'b0, decay_coeff};
    total    = 34'(p_old) + 34'(p_new) + 34'(ONE_Q15);
    sm_c     = (total[33:16] > 18'(LEVEL_MAX)) ? LEVEL_MAX : total[30:16];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      div_req.start  <= 1'b0;
      level_valid    <= 1'b0;
      smoothed_store <= '0;
    end else begin
      if (div_req.start) begin
        div_req.start <= 1'b0;
      end
      if (level_valid && !level_stall && state != ST_OUT) begin
        level_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!empty) begin
            div_req <= '{start: 1'b1, dividend: head.sum,
                         divisor: DIV_W'({head.count, 1'b0})};
            state   <= ST_MEAN;
          end
        end
        ST_MEAN: begin
          if (div_rsp.done) begin
            sq_val <= div_rsp.quotient;
            root   <= '0;
            srem   <= '0;
            steps  <= ROOT_STEP_W'(ROOT_W);
            state  <= ST_ROOT;
          end
        end
        ST_ROOT: begin
          sq_val <= {sq_val[SUM_W-3:0], 2'b00};
          if (sq_fit) begin
            srem <= ROOT_REM_W'(sq_sh - sq_trial);
            root <= {root[ROOT_W-2:0], 1'b1};
          end else begin
            srem <= ROOT_REM_W'(sq_sh);
            root <= {root[ROOT_W-2:0], 1'b0};
          end
          steps <= steps - 1'b1;
          if (steps == ROOT_STEP_W'(1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          rms   <= rms_c;
          p_old <= 31'(decay_coeff) * 31'(smoothed_store);
          p_new <= 32'(weight) * 32'(rms_c);
          state <= ST_SUM;
        end
        ST_SUM: begin
          smoothed_store <= sm_c;
          sm             <= sm_c;
          if (full_scale_level == '0) begin
            scaled <= (sm_c != '0) ? ONE_Q15 : '0;
            state  <= ST_OUT;
          end else begin
            div_req <= '{start: 1'b1, dividend: SUM_W'({sm_c, 15'b0}),
                         divisor: DIV_W'(full_scale_level)};
            state   <= ST_SCALE;
          end
        end
        ST_SCALE: begin
          if (div_rsp.done) begin
            scaled <= (div_rsp.quotient > SUM_W'(ONE_Q15)) ? ONE_Q15
                                                            : div_rsp.quotient[15:0];
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!level_valid || !level_stall) begin
            level_valid <= 1'b1;
            level       <= '{smoothed_level: sm, scaled_level: scaled, block_rms: rms};
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[dv/rms_level_checker.sv]
module rms_level_checker #(
  parameter int MAX_FRAMES = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  rlm_pkg::frame_t frame,
  input  logic            frame_valid,
  input  logic            frame_stall,
  input  rlm_pkg::level_t level,
  input  logic            level_valid,
  input  logic            level_stall,
  input  logic            write_enable,
  input  logic            reg_index,
  input  logic [15:0]     write_data,
  output int              pending,
  output int              errors
);
  import rlm_pkg::*;

  logic [SUM_W-1:0] sum_acc;
  logic [CNT_W-1:0] frames_seen;
  logic [15:0]      level_hist;
  logic [15:0]      decay;
  logic [14:0]      full_scale;
  level_t           expected_levels[$];

  initial begin
    pending = 0;
    errors  = 0;
  end

  task automatic report_mismatch(string msg);
    $display("%0t MISMATCH %s", $time, msg);
    errors++;
  endtask

  function automatic logic [63:0] int_sqrt(logic [SUM_W-1:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = ROOT_W - 1; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= 64'(v)) root = trial;
    end
    return root;
  endfunction

  // accumulate one frame; on block end, queue the level it produces
  task automatic take_frame(frame_t f);
    logic signed [31:0] sq;
    logic [SUM_W:0]     total;
    logic [SUM_W-1:0]   mean;
    logic [63:0]        rms;
    logic [63:0]        mix;
    logic [63:0]        sm;
    logic [63:0]        sc;
    level_t             want;
    sq = f.left_sample * f.left_sample;
    total = {1'b0, sum_acc} + (SUM_W + 1)'(sq[31:2]);
    sum_acc = total[SUM_W] ? '1 : total[SUM_W-1:0];
    frames_seen = frames_seen + 1'b1;
    if (!f.last_frame && frames_seen < MAX_FRAMES && frames_seen != 0) return;

    mean = (frames_seen == 0) ? '0 : sum_acc / {frames_seen, 1'b0};
    rms = int_sqrt(mean);
    if (rms > 64'(LEVEL_MAX)) rms = 64'(LEVEL_MAX);

    mix = 64'(decay) * 64'(level_hist) + 64'(17'h10000 - {1'b0, decay}) * rms + 64'd32768;
    sm = mix >> 16;
    if (sm > 64'(LEVEL_MAX)) sm = 64'(LEVEL_MAX);
    level_hist = sm[15:0];

    if (full_scale == 0) begin
      sc = (sm == 0) ? 64'd0 : 64'(ONE_Q15);
    end else begin
      sc = (sm << 15) / full_scale;
      if (sc > 64'(ONE_Q15)) sc = 64'(ONE_Q15);
    end

    want.smoothed_level = sm[14:0];
    want.scaled_level   = sc[15:0];
    want.block_rms      = rms[14:0];
    expected_levels = {expected_levels, want};
    sum_acc     = '0;
    frames_seen = '0;
  endtask

  always @(posedge clk) begin
    level_t want;
    if (rst) begin
      sum_acc     = '0;
      frames_seen = '0;
      level_hist  = '0;
      decay       = DECAY_RESET;
      full_scale  = FULL_SCALE_RESET;
      expected_levels.delete();
    end else begin
      if (write_enable) begin
        if (reg_index == REG_DECAY) decay = write_data;
        else full_scale = write_data[14:0];
      end
      if (frame_valid && !frame_stall) take_frame(frame);
      if (level_valid && !level_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("level with no request pending: %0d/%0d/%0d",
                                    level.smoothed_level, level.scaled_level,
                                    level.block_rms));
        end else begin
          want = expected_levels.pop_front();
          if (level.smoothed_level !== want.smoothed_level)
            report_mismatch($sformatf("smoothed_level got %0d want %0d",
                                      level.smoothed_level, want.smoothed_level));
          if (level.scaled_level !== want.scaled_level)
            report_mismatch($sformatf("scaled_level got %0d want %0d",
                                      level.scaled_level, want.scaled_level));
          if (level.block_rms !== want.block_rms)
            report_mismatch($sformatf("block_rms got %0d want %0d",
                                      level.block_rms, want.block_rms));
        end
      end
    end
    pending = expected_levels.size();
  end

endmodule

[dv/rms_level_meter_smoothed_tb.sv]
module rms_level_meter_smoothed_tb;
  import rlm_pkg::*;

  localparam int MAX_FRAMES   = 256;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES  = 1500;

  logic        clk;
  logic        rst          = 1'b1;
  frame_t      frame        = '0;
  logic        frame_valid  = 1'b0;
  logic        frame_stall;
  level_t      level;
  logic        level_valid;
  logic        level_stall  = 1'b0;
  logic        write_enable = 1'b0;
  logic        reg_index    = REG_DECAY;
  logic [15:0] write_data   = '0;

  int pending;
  int errors;
  int cycles       = 0;
  bit gaps_on      = 1'b1;
  bit hold_request = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  rms_level_meter_smoothed #(.MAX_FRAMES(MAX_FRAMES)) uut (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .level       (level),
    .level_valid (level_valid),
    .level_stall (level_stall),
    .write_enable(write_enable),
    .reg_index   (reg_index),
    .write_data  (write_data)
  );

  rms_level_checker #(.MAX_FRAMES(MAX_FRAMES)) level_check (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .level       (level),
    .level_valid (level_valid),
    .level_stall (level_stall),
    .write_enable(write_enable),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .pending     (pending),
    .errors      (errors)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // level receiver: random stalls, or one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        level_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        level_stall <= 1'b0;
      end else begin
        level_stall <= gaps_on && ($urandom_range(99) < 7);
      end
    end
  end

  task automatic send_frame(logic signed [15:0] left, logic last);
    frame_t f;
    f.left_sample  = left;
    f.right_sample = 16'($urandom);
    f.last_frame   = last;
    if (gaps_on && $urandom_range(99) < 7) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame       <= f;
    frame_valid <= 1'b1;
    do @(posedge clk); while (frame_stall);
  endtask

  task automatic write_config(logic [15:0] decay_word, logic [15:0] scale_word);
    write_enable <= 1'b1;
    reg_index    <= REG_DECAY;
    write_data   <= decay_word;
    @(posedge clk);
    reg_index    <= REG_FULL_SCALE;
    write_data   <= scale_word;
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  task automatic drain();
    frame_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      4, 5:    return 16'($urandom_range(511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_blocks(int count);
    int frames_left = 0;
    for (int k = 0; k < count; k++) begin
      if (frames_left == 0)
        frames_left = ($urandom_range(3) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      frames_left--;
      send_frame(pick_sample(), frames_left == 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset config: sample extremes, multi-frame blocks
    send_frame(16'sh8000, 1'b1);
    send_frame(16'sh7FFF, 1'b1);
    send_frame(16'sh0000, 1'b1);
    send_frame(16'sh0001, 1'b0);
    send_frame(-16'sd1, 1'b0);
    send_frame(16'sh4000, 1'b1);
    send_frame(16'sh8000, 1'b0);
    send_frame(16'sh8000, 1'b1);
    drain();

    // no smoothing, tiny full scale: scaled clamps
    write_config(16'h0000, 16'h0001);
    send_frame(16'sh7FFF, 1'b1);
    send_frame(16'sh0100, 1'b1);
    drain();

    // max decay, max full scale
    write_config(16'hFFFF, 16'h7FFF);
    send_frame(16'sh8000, 1'b1);
    send_frame(16'sh1234, 1'b1);
    drain();

    // full scale of zero (bit 15 of the write is dropped)
    write_config(16'h0000, 16'h8000);
    send_frame(16'sh0000, 1'b1);
    send_frame(16'sh0400, 1'b1);
    send_frame(16'sh0000, 1'b1);
    drain();

    for (int p = 0; p < 3; p++) begin
      write_config(16'($urandom), 16'($urandom));
      run_blocks(40);
      drain();
    end

    // no idling on either side
    gaps_on = 1'b0;
    write_config(16'($urandom), 16'($urandom_range(1, 32767)));
    run_blocks(80);
    drain();
    gaps_on = 1'b1;

    // receiver holds off while block ends pile up
    write_config(16'($urandom), 16'($urandom_range(1, 32767)));
    hold_request = 1'b1;
    for (int k = 0; k < 24; k++) send_frame(pick_sample(), 1'b1);
    drain();

    // block too long: ends on its own at MAX_FRAMES
    write_config(16'($urandom), 16'($urandom_range(1, 32767)));
    for (int k = 0; k < MAX_FRAMES; k++) send_frame(pick_sample(), 1'b0);
    run_blocks(20);
    drain();

    write_config(DECAY_RESET, {1'b0, FULL_SCALE_RESET});
    run_blocks(40);
    drain();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rlm_pkg.sv
hdl/rlm_div.sv
hdl/rlm_fifo.sv
hdl/rlm_front.sv
hdl/rlm_back.sv
hdl/rms_level_meter_smoothed.sv
dv/rms_level_checker.sv
dv/rms_level_meter_smoothed_tb.sv
